// ===== rtl/core/gregorian_julian_day_converter_defines.svh =====
// ----------------------------------------------------------------------------
// Gregorian / Julian day converter assertion macros
// Shared concurrent assertion forms used by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_JULIAN_DAY_CONVERTER_DEFINES_SVH
`define GREGORIAN_JULIAN_DAY_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GJD_ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("gjd: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GJD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("gjd: next-cycle check failed");

`endif

// ===== rtl/core/gjd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian / Julian day converter package
// Pipeline depth, command codes, result types and the month offset table.
// ----------------------------------------------------------------------------
package gjd_pkg;

  localparam int NUM_STAGES     = 10;
  // Stage at which the date-to-day result is final; later stages only carry it.
  localparam int D2J_DONE_STAGE = 4;

  localparam logic CMD_DATE_TO_DAY = 1'b0;
  localparam logic CMD_DAY_TO_DATE = 1'b1;

  // Day number of 16383-12-31, the last date the year field can hold.
  localparam logic [22:0] DAY_NUMBER_TOP = 23'd7705192;

  typedef struct packed {
    logic [22:0] day_number;
    logic        invalid;
  } d2j_res_t;

  typedef struct packed {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } j2d_res_t;

  // Days before month index k in a March-based year. The same values result
  // from 367*k/12 and from 2447*k/80 over the whole 4-bit range.
  function automatic logic [8:0] days_before_month(input logic [3:0] k);
    logic [8:0] v;
    case (k)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd152;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd305;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      4'd15:   v = 9'd458;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/gjd_pipe_ctrl.sv =====
`timescale 1ns / 1ps
`include "gregorian_julian_day_converter_defines.svh"
// ----------------------------------------------------------------------------
// Converter pipeline control
// Per-stage valid bits and load enables with bubble collapsing.
// ----------------------------------------------------------------------------
module gjd_pipe_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            out_ready,
  output logic                            in_ready,
  output logic                            out_valid,
  output logic [gjd_pkg::NUM_STAGES-1:0] stage_en
);
  import gjd_pkg::*;

  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [NUM_STAGES-1:0] upstream;
  logic [NUM_STAGES:0]   load;

  // A stage loads when it is empty or when its content moves on.
  always_comb begin
    load[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      load[k] = !valid_r[k] || load[k+1];
    end
  end

  assign upstream  = {valid_r[NUM_STAGES-2:0], in_valid};
  assign valid_nxt = (load[NUM_STAGES-1:0] & upstream) | (~load[NUM_STAGES-1:0] & valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = valid_r[NUM_STAGES-1];
  assign stage_en  = load[NUM_STAGES-1:0];

  `GJD_ASSERT_IMPLIES(a_bubble_accepts, clk, rst_n, !(&valid_r), in_ready)
  `GJD_ASSERT_NEXT(a_accept_fills_head, clk, rst_n, in_valid && in_ready, valid_r[0])
  `GJD_ASSERT_IMPLIES(a_item_count, clk, rst_n, $past(rst_n), $countones(valid_r) == $countones($past(valid_r)) + ($past(in_valid && in_ready) ? 1 : 0) - ($past(out_valid && out_ready) ? 1 : 0))

endmodule

// ===== rtl/core/gjd_date_to_day.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date to day number datapath
// Pipelined Gregorian date to Julian day number conversion.
// ----------------------------------------------------------------------------
module gjd_date_to_day (
  input  logic                            clk,
  input  logic [gjd_pkg::NUM_STAGES-1:0] stage_en,
  input  logic                            command,
  input  logic [14:0]                     year,
  input  logic [3:0]                      month,
  input  logic [5:0]                      day,
  output gjd_pkg::d2j_res_t               res
);
  import gjd_pkg::*;

  // Stage 0: offsets and the month table.
  logic        early;
  logic [15:0] year_x, t1_nxt, t3, t3_abs;
  logic [3:0]  k;
  logic        s0_cmd_r, s0_inv_r, s0_neg_r;
  logic [15:0] s0_t1_r;
  logic [14:0] s0_t3_abs_r;
  logic [8:0]  s0_term2_r;
  logic [5:0]  s0_day_r;

  assign early  = (month <= 4'd2);
  assign year_x = {year[14], year};
  assign t1_nxt = year_x + 16'd4800 - {15'd0, early};
  assign t3     = year_x + 16'd4900 - {15'd0, early};
  assign t3_abs = t3[15] ? (16'd0 - t3) : t3;
  assign k      = early ? (month + 4'd10) : (month - 4'd2);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s0_cmd_r    <= command;
      s0_inv_r    <= (month > 4'd12) || (day > 6'd31);
      s0_t1_r     <= t1_nxt;
      s0_neg_r    <= t3[15];
      s0_t3_abs_r <= t3_abs[14:0];
      s0_term2_r  <= days_before_month(k);
      s0_day_r    <= day;
    end
  end

  // Stage 1: the two multiplications (year term and reciprocal of 100).
  logic        s1_cmd_r, s1_inv_r, s1_neg_r;
  logic [26:0] s1_p_r;
  logic [27:0] s1_qp_r;
  logic [8:0]  s1_term2_r;
  logic [5:0]  s1_day_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_cmd_r   <= s0_cmd_r;
      s1_inv_r   <= s0_inv_r;
      s1_neg_r   <= s0_neg_r;
      s1_p_r     <= {{11{s0_t1_r[15]}}, s0_t1_r} * 27'd1461;
      s1_qp_r    <= {13'd0, s0_t3_abs_r} * 28'd5243;
      s1_term2_r <= s0_term2_r;
      s1_day_r   <= s0_day_r;
    end
  end

  // Stage 2: quarter with truncation toward zero, century correction.
  logic [26:0] p_adj;
  logic [7:0]  q;
  logic [9:0]  q3;
  logic        s2_cmd_r, s2_inv_r, s2_neg_r;
  logic [24:0] s2_term1_r;
  logic [7:0]  s2_mag_r;
  logic [8:0]  s2_term2_r;
  logic [5:0]  s2_day_r;

  assign p_adj = s1_p_r + {25'd0, s1_p_r[26], s1_p_r[26]};
  assign q     = s1_qp_r[26:19];
  assign q3    = {1'b0, q, 1'b0} + {2'b00, q};

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_inv_r   <= s1_inv_r;
      s2_neg_r   <= s1_neg_r;
      s2_term1_r <= p_adj[26:2];
      s2_mag_r   <= q3[9:2];
      s2_term2_r <= s1_term2_r;
      s2_day_r   <= s1_day_r;
    end
  end

  // Stage 3: sum of all terms.
  logic [24:0] term3_neg;
  logic        s3_cmd_r, s3_inv_r;
  logic [24:0] s3_sum_r;

  assign term3_neg = s2_neg_r ? {17'd0, s2_mag_r} : (25'd0 - {17'd0, s2_mag_r});

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_cmd_r <= s2_cmd_r;
      s3_inv_r <= s2_inv_r;
      s3_sum_r <= s2_term1_r + {16'd0, s2_term2_r} + {19'd0, s2_day_r} - 25'd32075
                  + term3_neg;
    end
  end

  // Stage 4: clamp and final selection; later stages carry the result.
  d2j_res_t done;
  d2j_res_t dly_r [D2J_DONE_STAGE:NUM_STAGES-1];

  always_comb begin
    done = '0;
    if (s3_cmd_r == CMD_DATE_TO_DAY) begin
      if (s3_inv_r) begin
        done.invalid = 1'b1;
      end else if (s3_sum_r[24]) begin
        done.day_number = '0;
      end else if (s3_sum_r[23]) begin
        done.day_number = '1;
      end else begin
        done.day_number = s3_sum_r[22:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[D2J_DONE_STAGE]) begin
      dly_r[D2J_DONE_STAGE] <= done;
    end
  end

  for (genvar s = D2J_DONE_STAGE + 1; s < NUM_STAGES; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        dly_r[s] <= dly_r[s-1];
      end
    end
  end

  assign res = dly_r[NUM_STAGES-1];

endmodule

// ===== rtl/core/gjd_day_to_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day number to date datapath
// Pipelined Julian day number to Gregorian date conversion.
// ----------------------------------------------------------------------------
module gjd_day_to_date (
  input  logic                            clk,
  input  logic [gjd_pkg::NUM_STAGES-1:0] stage_en,
  input  logic                            command,
  input  logic [22:0]                     day_number,
  output gjd_pkg::j2d_res_t               res
);
  import gjd_pkg::*;

  // Command bit travels alongside the data.
  logic [NUM_STAGES-1:0] cmd_r;
  logic [NUM_STAGES-1:0] cmd_in;

  assign cmd_in = {cmd_r[NUM_STAGES-2:0], command};

  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (stage_en[s]) begin
        cmd_r[s] <= cmd_in[s];
      end
    end
  end

  // Stage 0: saturate and offset.
  logic [22:0] jc, l0;
  logic [24:0] s0_x_r;

  assign jc = (day_number > DAY_NUMBER_TOP) ? DAY_NUMBER_TOP : day_number;
  assign l0 = jc + 23'd68569;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s0_x_r <= {l0, 2'b00};
    end
  end

  // Stage 1: reciprocal product for the 400-year cycle count.
  logic [39:0] s1_p1_r;
  logic [24:0] s1_x_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_p1_r <= {15'd0, s0_x_r} * 40'd29398;
      s1_x_r  <= s0_x_r;
    end
  end

  // Stage 2: quotient estimate and its remainder.
  logic [7:0]  q0;
  logic [25:0] q0_prod, diff0;
  logic [7:0]  s2_q_r;
  logic [18:0] s2_rem_r;

  assign q0      = s1_p1_r[39:32];
  assign q0_prod = {18'd0, q0} * 26'd146097;
  assign diff0   = {1'b0, s1_x_r} - q0_prod;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s2_q_r   <= q0;
      s2_rem_r <= diff0[18:0];
    end
  end

  // Stage 3: one correction step; the day within the cycle is rem / 4.
  logic        ge0;
  logic [18:0] r0;
  logic [7:0]  s3_n_r;
  logic [15:0] s3_l2_r;

  assign ge0 = (s2_rem_r >= 19'd146097);
  assign r0  = ge0 ? (s2_rem_r - 19'd146097) : s2_rem_r;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_n_r  <= s2_q_r + {7'd0, ge0};
      s3_l2_r <= r0[17:2];
    end
  end

  // Stage 4: reciprocal product for the year within the cycle.
  logic [16:0] lp1;
  logic [43:0] s4_p2_r;
  logic [27:0] s4_num_r;
  logic [15:0] s4_l2_r;
  logic [7:0]  s4_n_r;

  assign lp1 = {1'b0, s3_l2_r} + 17'd1;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s4_p2_r  <= {27'd0, lp1} * 44'd188140000;
      s4_num_r <= {11'd0, lp1} * 28'd4000;
      s4_l2_r  <= s3_l2_r;
      s4_n_r   <= s3_n_r;
    end
  end

  // Stage 5: quotient estimate and its remainder.
  logic [6:0]  qi0;
  logic [27:0] qi_prod, diff1;
  logic [6:0]  s5_qi_r;
  logic [21:0] s5_rem_r;
  logic [15:0] s5_l2_r;
  logic [7:0]  s5_n_r;

  assign qi0     = s4_p2_r[42:36];
  assign qi_prod = {21'd0, qi0} * 28'd1461001;
  assign diff1   = s4_num_r - qi_prod;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s5_qi_r  <= qi0;
      s5_rem_r <= diff1[21:0];
      s5_l2_r  <= s4_l2_r;
      s5_n_r   <= s4_n_r;
    end
  end

  // Stage 6: correction and the century part of the year.
  logic        ge1;
  logic [6:0]  s6_i_r;
  logic [15:0] s6_ybase_r;
  logic [15:0] s6_l2_r;

  assign ge1 = (s5_rem_r >= 22'd1461001);

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      s6_i_r     <= s5_qi_r + {6'd0, ge1};
      s6_ybase_r <= {8'd0, s5_n_r} * 16'd100 - 16'd4900;
      s6_l2_r    <= s5_l2_r;
    end
  end

  // Stage 7: day within the March-based year.
  logic [17:0] ip;
  logic [16:0] l3;
  logic [10:0] s7_l3_r;
  logic [6:0]  s7_i_r;
  logic [15:0] s7_ybase_r;

  assign ip = {11'd0, s6_i_r} * 18'd1461;
  assign l3 = {1'b0, s6_l2_r} + 17'd31 - {1'b0, ip[17:2]};

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      s7_l3_r    <= l3[10:0];
      s7_i_r     <= s6_i_r;
      s7_ybase_r <= s6_ybase_r;
    end
  end

  // Stage 8: reciprocal product for the month index.
  logic [34:0] s8_p3_r;
  logic [10:0] s8_l3_r;
  logic [6:0]  s8_i_r;
  logic [15:0] s8_ybase_r;

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      s8_p3_r    <= {24'd0, s7_l3_r} * 35'd8776000;
      s8_l3_r    <= s7_l3_r;
      s8_i_r     <= s7_i_r;
      s8_ybase_r <= s7_ybase_r;
    end
  end

  // Stage 9: month, day and year.
  logic [3:0]  j;
  logic        wrap;
  logic [10:0] dfull;
  logic [15:0] yfull;
  j2d_res_t    fields, res_r;

  assign j     = s8_p3_r[31:28];
  assign wrap  = (j >= 4'd11);
  assign dfull = s8_l3_r - {2'b00, days_before_month(j)};
  assign yfull = s8_ybase_r + {9'd0, s8_i_r} + {15'd0, wrap};

  always_comb begin
    fields = '0;
    if (cmd_r[NUM_STAGES-2] == CMD_DAY_TO_DATE) begin
      fields.year  = yfull[14:0];
      fields.month = j + 4'd2 - (wrap ? 4'd12 : 4'd0);
      fields.day   = dfull[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      res_r <= fields;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/gregorian_julian_day_converter.sv =====
`timescale 1ns / 1ps
`include "gregorian_julian_day_converter_defines.svh"
// ----------------------------------------------------------------------------
// Gregorian / Julian day number converter
// Pipelined converter between proleptic Gregorian dates and day numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction carries a command and both sets of operands.
//   Command date-to-day takes year, month and day and returns the Julian day
//   number; a month above 12 or a day above 31 sets invalid and returns zero.
//   Command day-to-date splits a day number into year, month and day. The
//   fields that the command does not produce are returned as zero.
//   Both channels use valid/ready; one result transaction per input.
//   The pipeline takes a new transaction every cycle while in_ready is high;
//   the ten stages are set by the chain of reciprocal multiplications and
//   remainder corrections in the day-to-date path. Results leave in the
//   order the inputs arrived. When the receiver holds out_ready low, the
//   last stage holds its result and stages behind it keep filling until the
//   pipeline is full; empty stages are squeezed out, so in_ready stays high
//   while any stage is empty. Reset (rst_n low, synchronous) empties the
//   pipeline; nothing is stored between transactions.
// ----------------------------------------------------------------------------
module gregorian_julian_day_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [14:0] in_year_in,
  input  logic        [3:0]  in_month_in,
  input  logic        [5:0]  in_day_in,
  input  logic        [22:0] in_day_number_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [22:0] out_day_number_out,
  output logic signed [14:0] out_year_out,
  output logic        [3:0]  out_month_out,
  output logic        [4:0]  out_day_out,
  output logic               out_invalid
);
  import gjd_pkg::*;

  logic [NUM_STAGES-1:0] stage_en;
  d2j_res_t              d2j_res;
  j2d_res_t              j2d_res;
  logic                  others_zero;

  // Valid bits and per-stage load enables shared by both datapaths.
  gjd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .stage_en  (stage_en)
  );

  // Each path zeroes its own fields when the other command was requested,
  // so the outputs combine without a final multiplexer.
  gjd_date_to_day u_d2j (
    .clk      (clk),
    .stage_en (stage_en),
    .command  (in_command),
    .year     (in_year_in),
    .month    (in_month_in),
    .day      (in_day_in),
    .res      (d2j_res)
  );

  gjd_day_to_date u_j2d (
    .clk        (clk),
    .stage_en   (stage_en),
    .command    (in_command),
    .day_number (in_day_number_in),
    .res        (j2d_res)
  );

  assign out_day_number_out = d2j_res.day_number;
  assign out_invalid        = d2j_res.invalid;
  assign out_year_out       = j2d_res.year;
  assign out_month_out      = j2d_res.month;
  assign out_day_out        = j2d_res.day;

  // An invalid date leaves every other result field at zero.
  assign others_zero = (out_day_number_out == '0) && (out_year_out == '0) &&
                       (out_month_out == '0) && (out_day_out == '0);

  `GJD_ASSERT_IMPLIES(a_invalid_clears, clk, rst_n, out_valid && out_invalid, others_zero)

endmodule
